/* rtl/pm_reading_display_smoother_top_defines.svh */
// ----------------------------------------------------------------------------
// pm reading display smoother assertion macros
// shared property forms used by the smoother rtl
// ----------------------------------------------------------------------------
`ifndef PM_READING_DISPLAY_SMOOTHER_TOP_DEFINES_SVH
`define PM_READING_DISPLAY_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PMDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PMDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pmds_pkg.sv */
// ----------------------------------------------------------------------------
// pmds_pkg
// types and constants of the pm reading display smoother
// ----------------------------------------------------------------------------
`default_nettype none

package pmds_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SECONDS_W = 32;
	localparam int DISPLAY_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_WINDOW      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_WINDOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STANDBY_PERIOD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EARLY_UPTIME    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_FLOOR   = 3'd5;

	// run mode codes
	localparam logic [1:0] MODE_STANDBY = 2'd0;
	localparam logic [1:0] MODE_RUNNING = 2'd1;

	typedef struct packed {
		logic [SECONDS_W-1:0] now_seconds;
		logic [SAMPLE_W-1:0]  pm_sample;
		logic [1:0]           op_mode;
		logic [SECONDS_W-1:0] start_seconds;
		logic [SECONDS_W-1:0] stop_seconds;
	} tick_t;

	typedef struct packed {
		logic [DISPLAY_W-1:0] display_value;
		logic                 sample_taken;
	} result_t;

	typedef struct packed {
		logic [7:0]  sample_interval;
		logic [15:0] run_window;
		logic [15:0] stop_window;
		logic [15:0] standby_period;
		logic [15:0] early_uptime;
		logic [15:0] display_floor;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/pmds_cfg.sv */
// ----------------------------------------------------------------------------
// pmds_cfg
// configuration register file of the display smoother
// ----------------------------------------------------------------------------
`default_nettype none

module pmds_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pmds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pmds_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output pmds_pkg::cfg_t                            cfg
);

	pmds_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval <= 8'd2;
			cfg_q.run_window      <= 16'd60;
			cfg_q.stop_window     <= 16'd600;
			cfg_q.standby_period  <= 16'd900;
			cfg_q.early_uptime    <= 16'd180;
			cfg_q.display_floor   <= 16'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmds_pkg::CFG_SAMPLE_INTERVAL: cfg_q.sample_interval <= cfg_wdata[7:0];
				pmds_pkg::CFG_RUN_WINDOW:      cfg_q.run_window      <= cfg_wdata;
				pmds_pkg::CFG_STOP_WINDOW:     cfg_q.stop_window     <= cfg_wdata;
				pmds_pkg::CFG_STANDBY_PERIOD:  cfg_q.standby_period  <= cfg_wdata;
				pmds_pkg::CFG_EARLY_UPTIME:    cfg_q.early_uptime    <= cfg_wdata;
				pmds_pkg::CFG_DISPLAY_FLOOR:   cfg_q.display_floor   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/pmds_core.sv */
// ----------------------------------------------------------------------------
// pmds_core
// smoother state and its single-pass update for one tick transaction
// ----------------------------------------------------------------------------
`default_nettype none

`include "pm_reading_display_smoother_top_defines.svh"

module pmds_core #(
	parameter int VALUE_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  pmds_pkg::tick_t        tick_s1,
	input  pmds_pkg::cfg_t         cfg,
	output pmds_pkg::result_t      result
);

	localparam int VW = VALUE_WIDTH;
	localparam int TW = TIME_WIDTH;
	localparam int SW = VALUE_WIDTH + 2;
	localparam int DW = pmds_pkg::DISPLAY_W;
	// reciprocal of three, exact to within one for sums below 2**SW
	localparam logic [SW-1:0] RECIP3 = SW'((64'd1 << SW) / 64'd3);

	logic [VW-1:0] latest_q, backup_q, shown_q, peak_q;
	logic [TW-1:0] rdue_q, sdue_q;
	logic          powered_q, phase_q;

	logic [VW-1:0] latest_n, backup_n, shown_n, peak_n;
	logic [TW-1:0] rdue_n, sdue_n;
	logic          powered_n, phase_n;

	logic [TW-1:0] now_t, start_t, stop_t;
	logic [TW-1:0] si_t, run_win_t, stop_win_t, period_t, early_t;
	logic [TW-1:0] now_plus_si, now_plus_period, rdue_wrap;
	logic          take;
	logic [VW-1:0] latest1, floor_v, shown_f;
	logic          grow;
	logic [VW-1:0] backup1, peak1, shown1;
	logic [VW-1:0] half_lb, half_bs, half_ls, half_pb, third;
	logic [SW-1:0] sum3;
	logic [2*SW-1:0] prod3;
	logic [SW-1:0] q3, r3;

	assign now_t      = TW'(tick_s1.now_seconds);
	assign start_t    = TW'(tick_s1.start_seconds);
	assign stop_t     = TW'(tick_s1.stop_seconds);
	assign si_t       = TW'(cfg.sample_interval);
	assign run_win_t  = TW'(cfg.run_window);
	assign stop_win_t = TW'(cfg.stop_window);
	assign period_t   = TW'(cfg.standby_period);
	assign early_t    = TW'(cfg.early_uptime);
	assign floor_v    = VW'(cfg.display_floor);

	assign now_plus_si     = now_t + si_t;
	assign now_plus_period = now_t + period_t;

	// read due time pulled back when the seconds count has wrapped
	assign rdue_wrap = (now_t <= si_t && rdue_q >= ({TW{1'b1}} - si_t)) ? now_plus_si : rdue_q;
	assign take      = now_t >= rdue_wrap;
	assign latest1   = take ? VW'(tick_s1.pm_sample) : latest_q;

	assign grow    = backup_q < latest1;
	assign backup1 = grow ? latest1 : backup_q;
	assign peak1   = (peak_q <= latest1) ? latest1 : peak_q;

	assign half_lb = VW'((SW'(latest1) + SW'(backup_q)) >> 1);
	assign half_bs = VW'((SW'(backup_q) + SW'(shown_q)) >> 1);
	assign half_ls = VW'((SW'(latest1) + SW'(shown_q)) >> 1);
	assign shown1  = grow ? half_ls : shown_q;
	assign half_pb = VW'((SW'(peak1) + SW'(backup1)) >> 1);

	// divide by three: reciprocal multiply, then one correction step
	assign sum3  = SW'(latest1) + SW'(shown_q) + SW'(backup_q);
	assign prod3 = {{SW{1'b0}}, sum3} * {{SW{1'b0}}, RECIP3};
	assign q3    = prod3[2*SW-1:SW];
	assign r3    = sum3 - SW'(q3 * SW'(3));
	assign third = VW'((r3 >= SW'(3)) ? q3 + SW'(1) : q3);

	always_comb begin
		latest_n  = latest1;
		backup_n  = backup_q;
		shown_n   = shown_q;
		peak_n    = peak_q;
		rdue_n    = take ? now_plus_si : rdue_wrap;
		sdue_n    = sdue_q;
		powered_n = powered_q;
		phase_n   = phase_q;

		if (tick_s1.op_mode == pmds_pkg::MODE_RUNNING) begin
			powered_n = 1'b1;
			phase_n   = 1'b0;
			if (now_t <= start_t + run_win_t) begin
				backup_n = (now_t <= early_t && grow) ? latest1 : backup_q;
				shown_n  = backup_n;
			end else begin
				shown_n  = half_lb;
				backup_n = latest1;
			end
		end else if (tick_s1.op_mode == pmds_pkg::MODE_STANDBY) begin
			priority if (!powered_q) begin
				if (now_t < period_t) begin
					backup_n = backup1;
					shown_n  = backup1;
				end else begin
					powered_n = 1'b1;
					phase_n   = 1'b1;
					peak_n    = '0;
					sdue_n    = now_plus_period;
				end
			end else if (!phase_q) begin
				if (now_t < stop_t + stop_win_t) begin
					shown_n = (latest1 < backup_q) ? half_bs : third;
				end else begin
					phase_n = 1'b1;
					peak_n  = '0;
					sdue_n  = now_plus_period;
				end
			end else begin
				if (now_t >= sdue_q) begin
					shown_n  = half_pb;
					backup_n = half_pb;
					peak_n   = '0;
					sdue_n   = sdue_q + period_t;
				end else begin
					peak_n   = peak1;
					backup_n = backup1;
					shown_n  = shown1;
				end
			end
		end
	end

	assign shown_f = (shown_n < floor_v) ? floor_v : shown_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q  <= '0;
			backup_q  <= '0;
			shown_q   <= '0;
			peak_q    <= '0;
			rdue_q    <= '0;
			sdue_q    <= '0;
			powered_q <= 1'b0;
			phase_q   <= 1'b0;
		end else if (advance) begin
			latest_q  <= latest_n;
			backup_q  <= backup_n;
			shown_q   <= shown_f;
			peak_q    <= peak_n;
			rdue_q    <= rdue_n;
			sdue_q    <= sdue_n;
			powered_q <= powered_n;
			phase_q   <= phase_n;
		end
	end

	assign result.display_value = DW'(shown_f);
	assign result.sample_taken  = take;

	`PMDS_ASSERT_NEXT(a_powered_sticky, clk, arst_n, powered_q, powered_q, "powered flag cleared")
	`PMDS_ASSERT_IMPLY(a_phase_needs_power, clk, arst_n, phase_q, powered_q, "periodic phase without power")
	`PMDS_ASSERT_NEXT(a_floor_held, clk, arst_n, advance, shown_q >= $past(floor_v), "shown value below floor")

endmodule

`default_nettype wire

/* rtl/pm_reading_display_smoother_top.sv */
// an accepted tick waits in the input register until advance loads its result register
// throughput: one tick transaction per cycle unless the result register stalls;
// state update is one pass between the input register and the result register
// a stalled result register holds the input register, which then holds tick_ready low
// reset: arst_n clears valid and core state, loads cfg defaults, no clearing pass
// ----------------------------------------------------------------------------
// pm_reading_display_smoother_top
// smoothed pm display value from periodic tick transactions
// ----------------------------------------------------------------------------
`default_nettype none

`include "pm_reading_display_smoother_top_defines.svh"

module pm_reading_display_smoother_top #(
	parameter int VALUE_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              tick_valid,
	output logic                                   tick_ready,
	input  pmds_pkg::tick_t                        tick,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output pmds_pkg::result_t                      result,
	input  wire logic                              cfg_we,
	input  wire logic [pmds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pmds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	pmds_pkg::cfg_t    cfg;
	pmds_pkg::tick_t   tick_s1;
	logic              valid_s1;
	pmds_pkg::result_t result_n;
	pmds_pkg::result_t result_s2;
	logic              valid_s2;
	logic              advance;
	logic              accept;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign tick_ready = !valid_s1 || advance;
	assign accept     = tick_valid && tick_ready;

	pmds_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pmds_core #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.TIME_WIDTH  (TIME_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick_s1 (tick_s1),
		.cfg     (cfg),
		.result  (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1 <= tick;
		end
		if (advance) begin
			result_s2 <= result_n;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`PMDS_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, valid_s1, "accepted tick lost")
	`PMDS_ASSERT_NEXT(a_advance_fills_s2, clk, arst_n, advance, valid_s2, "result not presented")
	`PMDS_ASSERT_NEXT(a_result_held, clk, arst_n, valid_s2 && !result_ready, $stable(result_s2), "result moved")

endmodule

`default_nettype wire
